### rtl/core/fvf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fvf_pkg
// Shared types and constants of the flow / imu velocity fuser.
// ----------------------------------------------------------------------------
package fvf_pkg;

  localparam int unsigned ALPHA_TABLE_DEPTH = 64;

  localparam logic [15:0] SETTLE_RESET  = 16'd1000;
  localparam logic [15:0] MIN_ALT_RESET = 16'd26;

  // exp(-1/8) in unsigned Q0.32
  localparam logic [31:0] EXP_STEP_Q32 = 32'd3790295335;

  localparam logic [16:0] ONE_Q16 = 17'd65536;

  // leak step divider widths
  localparam int unsigned DIV_DW = 37;
  localparam int unsigned DIV_VW = 26;

  localparam logic [9:0]  MS_SCALE = 10'd1000;
  localparam logic [34:0] INC_BIAS = 35'd7812;

  // ceil(2^48 / 15625) split at bit 17, exact quotient for dividends below 2^34
  localparam logic [16:0] INC_RECIP_LO = 17'd124974;
  localparam logic [17:0] INC_RECIP_HI = 18'd137438;

  typedef enum logic [0:0] {
    REG_SETTLE  = 1'b0,
    REG_MIN_ALT = 1'b1
  } reg_idx_e;

  typedef enum logic [4:0] {
    ST_FILL,
    ST_IDLE,
    ST_PREP,
    ST_U_GO,
    ST_U_WAIT,
    ST_RD0,
    ST_RD1,
    ST_RD2,
    ST_INTERP,
    ST_ALPHA,
    ST_X_GO,
    ST_X_WAIT,
    ST_Y_GO,
    ST_Y_WAIT,
    ST_MUL,
    ST_SUM,
    ST_UPD,
    ST_OUT
  } back_st_e;

  typedef struct packed {
    logic signed [15:0] flow_x;
    logic signed [15:0] flow_y;
    logic signed [15:0] gyro_x;
    logic signed [15:0] gyro_y;
    logic signed [15:0] accel_x;
    logic signed [15:0] accel_y;
    logic [15:0]        altitude;
    logic [15:0]        dt_us;
    logic               skip;
  } item_t;

  typedef struct packed {
    logic              start;
    logic [DIV_DW-1:0] dividend;
    logic [DIV_VW-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [DIV_DW-1:0] quot;
  } div_rsp_t;

endpackage

### rtl/core/fvf_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fvf_ram
// Generic single write port, single read port ram with registered read.
// ----------------------------------------------------------------------------
module fvf_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/core/fvf_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fvf_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module fvf_div (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  fvf_pkg::div_req_t req_i,
  output fvf_pkg::div_rsp_t rsp_o
);

  localparam int unsigned DW = fvf_pkg::DIV_DW;
  localparam int unsigned VW = fvf_pkg::DIV_VW;
  localparam int unsigned CW = $clog2(DW + 1);

  logic [VW-1:0] rem_q, rem_d;
  logic [DW-1:0] quo_q, quo_d;
  logic [VW-1:0] dvs_q;
  logic [CW-1:0] cnt_q, cnt_d;
  logic          done_q, done_d;
  logic [VW:0]   rem_sh;
  logic [VW:0]   diff;
  logic          ge;

  always_comb begin
    rem_sh = {rem_q, quo_q[DW-1]};
    diff   = rem_sh - {1'b0, dvs_q};
    ge     = (rem_sh >= {1'b0, dvs_q});
    rem_d  = rem_q;
    quo_d  = quo_q;
    cnt_d  = cnt_q;
    done_d = 1'b0;
    if (req_i.start) begin
      rem_d = '0;
      quo_d = req_i.dividend;
      cnt_d = CW'(DW);
    end else if (cnt_q != '0) begin
      rem_d  = ge ? diff[VW-1:0] : rem_sh[VW-1:0];
      quo_d  = {quo_q[DW-2:0], ge};
      cnt_d  = cnt_q - CW'(1);
      done_d = (cnt_q == CW'(1));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    if (req_i.start) begin
      dvs_q <= req_i.divisor;
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quot = quo_q;

endmodule

### rtl/core/fvf_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fvf_front
// Accepts samples, marks zero time steps as skips, queues two entries.
// ----------------------------------------------------------------------------
module fvf_front (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  fvf_pkg::item_t in_item_i,
  output logic           q_valid_o,
  output fvf_pkg::item_t q_item_o,
  input  logic           q_pop_i
);

  fvf_pkg::item_t ent_q [2];
  fvf_pkg::item_t ent_d;
  logic           wr_q, rd_q;
  logic [1:0]     cnt_q;
  logic           push;

  assign in_ready_o = (cnt_q != 2'd2);
  assign push       = in_valid_i && in_ready_o;
  assign q_valid_o  = (cnt_q != 2'd0);
  assign q_item_o   = ent_q[rd_q];

  always_comb begin
    ent_d      = in_item_i;
    ent_d.skip = (in_item_i.dt_us == 16'd0);
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      ent_q[wr_q] <= ent_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push) begin
        wr_q <= ~wr_q;
      end
      if (q_pop_i) begin
        rd_q <= ~rd_q;
      end
      unique case ({push, q_pop_i})
        2'b10:   cnt_q <= cnt_q + 2'd1;
        2'b01:   cnt_q <= cnt_q - 2'd1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

endmodule

### rtl/core/fvf_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fvf_back
// Sequencer for the fusion arithmetic: alpha table, leak, trapezoid, mix.
// ----------------------------------------------------------------------------
module fvf_back #(
  parameter int unsigned ALPHA_TABLE_DEPTH = fvf_pkg::ALPHA_TABLE_DEPTH
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               q_valid_i,
  input  fvf_pkg::item_t     q_item_i,
  output logic               q_pop_o,
  input  logic [15:0]        settle_i,
  input  logic [15:0]        min_alt_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [31:0] vel_x_o,
  output logic signed [31:0] vel_y_o
);

  localparam int unsigned AW = $clog2(ALPHA_TABLE_DEPTH);
  localparam logic [AW-1:0] LAST_ADDR = AW'(ALPHA_TABLE_DEPTH - 1);

  fvf_pkg::back_st_e state_q, state_d;

  // table build
  logic [AW-1:0] fill_cnt_q;
  logic [31:0]   acc_q;
  logic [63:0]   acc_prod;
  logic [63:0]   acc_rnd;
  logic [32:0]   e_sum;
  logic [16:0]   e_val;

  // ram and divider
  logic              ram_we;
  logic [AW-1:0]     ram_waddr, ram_raddr;
  logic [15:0]       ram_wdata, ram_rdata;
  fvf_pkg::div_req_t div_req;
  fvf_pkg::div_rsp_t div_rsp;

  // datapath
  fvf_pkg::item_t     item_q;
  logic [25:0]        divisor_q;
  logic signed [33:0] cprod_x_q, cprod_y_q, num_x_q, num_y_q;
  logic signed [30:0] cam_x_q, cam_y_q;
  logic [36:0]        u_q;
  logic [16:0]        p0_q, p1_q, alpha_q;
  logic [32:0]        iprod_q;
  logic [51:0]        rcp_lo_q;
  logic [52:0]        rcp_hi_q;
  logic signed [23:0] inc_x_q, inc_y_q;
  logic signed [49:0] mv_x_q, mc_x_q, mv_y_q, mc_y_q, mix_x_q, mix_y_q;
  logic signed [31:0] vel_x_q, vel_y_q, out_x_q, out_y_q;
  logic signed [15:0] last_x_q, last_y_q;
  logic               seeded_q, out_valid_q, out_ld;

  logic [20:0]        idx;
  logic               over;
  logic [20:0]        idx_m1;
  logic [15:0]        settle_eff, alt_eff;
  logic signed [16:0] dfx, dfy, alt_s, dt_s, lsum_x, lsum_y;
  logic signed [15:0] last_eff_x, last_eff_y;
  logic [33:0]        mag_x, mag_y;
  logic [34:0]        dvd_x, dvd_y;
  logic [69:0]        rcp_sum;
  logic [23:0]        inc_mag;
  logic signed [33:0] cam_sum_x, cam_sum_y;
  logic [33:0]        irnd;
  logic signed [17:0] a_s, b_s;
  logic signed [34:0] tot_x, tot_y;
  logic signed [31:0] sat_x, sat_y;

  fvf_ram #(
    .WIDTH(16),
    .DEPTH(ALPHA_TABLE_DEPTH)
  ) u_alpha_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  fvf_div u_div (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (div_req),
    .rsp_o (div_rsp)
  );

  // ---- combinational helpers
  always_comb begin
    acc_prod = 64'(acc_q) * 64'(fvf_pkg::EXP_STEP_Q32);
    acc_rnd  = acc_prod + 64'h0000_0000_8000_0000;
    e_sum    = 33'(acc_q) + 33'd32768;
    e_val    = e_sum[32:16];

    idx    = u_q[36:16];
    over   = (idx >= 21'(ALPHA_TABLE_DEPTH));
    idx_m1 = idx - 21'd1;

    settle_eff = (settle_i == 16'd0) ? 16'd1 : settle_i;
    alt_eff    = (item_q.altitude < min_alt_i) ? min_alt_i : item_q.altitude;
    alt_s      = $signed({1'b0, alt_eff});
    dt_s       = $signed({1'b0, item_q.dt_us});
    dfx        = $signed({item_q.flow_x[15], item_q.flow_x})
               - $signed({item_q.gyro_x[15], item_q.gyro_x});
    dfy        = $signed({item_q.flow_y[15], item_q.flow_y})
               - $signed({item_q.gyro_y[15], item_q.gyro_y});
    last_eff_x = seeded_q ? last_x_q : item_q.accel_x;
    last_eff_y = seeded_q ? last_y_q : item_q.accel_y;
    lsum_x     = $signed({item_q.accel_x[15], item_q.accel_x})
               + $signed({last_eff_x[15], last_eff_x});
    lsum_y     = $signed({item_q.accel_y[15], item_q.accel_y})
               + $signed({last_eff_y[15], last_eff_y});

    mag_x = num_x_q[33] ? 34'(-num_x_q) : 34'(num_x_q);
    mag_y = num_y_q[33] ? 34'(-num_y_q) : 34'(num_y_q);

    // trapezoid increment: (2*|num| + 7812) / 15625 by reciprocal multiply
    dvd_x   = 35'({mag_x, 1'b0}) + fvf_pkg::INC_BIAS;
    dvd_y   = 35'({mag_y, 1'b0}) + fvf_pkg::INC_BIAS;
    rcp_sum = (70'(rcp_hi_q) << 17) + 70'(rcp_lo_q);
    inc_mag = 24'(rcp_sum[69:48]);

    cam_sum_x = cprod_x_q + 34'sd4;
    cam_sum_y = cprod_y_q + 34'sd4;

    irnd = 34'(iprod_q) + 34'd32768;

    a_s = $signed({1'b0, alpha_q});
    b_s = $signed({1'b0, fvf_pkg::ONE_Q16 - alpha_q});

    tot_x = 35'($signed(mix_x_q[49:16])) + 35'(inc_x_q);
    tot_y = 35'($signed(mix_y_q[49:16])) + 35'(inc_y_q);
    if (tot_x > 35'sh0_7FFF_FFFF) begin
      sat_x = 32'sh7FFF_FFFF;
    end else if (tot_x < -35'sh0_8000_0000) begin
      sat_x = 32'sh8000_0000;
    end else begin
      sat_x = tot_x[31:0];
    end
    if (tot_y > 35'sh0_7FFF_FFFF) begin
      sat_y = 32'sh7FFF_FFFF;
    end else if (tot_y < -35'sh0_8000_0000) begin
      sat_y = 32'sh8000_0000;
    end else begin
      sat_y = tot_y[31:0];
    end
  end

  // ---- next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      fvf_pkg::ST_FILL:   if (fill_cnt_q == LAST_ADDR) state_d = fvf_pkg::ST_IDLE;
      fvf_pkg::ST_IDLE: begin
        if (q_valid_i) begin
          state_d = q_item_i.skip ? fvf_pkg::ST_OUT : fvf_pkg::ST_PREP;
        end
      end
      fvf_pkg::ST_PREP:   state_d = fvf_pkg::ST_U_GO;
      fvf_pkg::ST_U_GO:   state_d = fvf_pkg::ST_U_WAIT;
      fvf_pkg::ST_U_WAIT: if (div_rsp.done) state_d = fvf_pkg::ST_RD0;
      fvf_pkg::ST_RD0:    state_d = fvf_pkg::ST_RD1;
      fvf_pkg::ST_RD1:    state_d = fvf_pkg::ST_RD2;
      fvf_pkg::ST_RD2:    state_d = fvf_pkg::ST_INTERP;
      fvf_pkg::ST_INTERP: state_d = fvf_pkg::ST_ALPHA;
      fvf_pkg::ST_ALPHA:  state_d = fvf_pkg::ST_X_GO;
      fvf_pkg::ST_X_GO:   state_d = fvf_pkg::ST_X_WAIT;
      fvf_pkg::ST_X_WAIT: state_d = fvf_pkg::ST_Y_GO;
      fvf_pkg::ST_Y_GO:   state_d = fvf_pkg::ST_Y_WAIT;
      fvf_pkg::ST_Y_WAIT: state_d = fvf_pkg::ST_MUL;
      fvf_pkg::ST_MUL:    state_d = fvf_pkg::ST_SUM;
      fvf_pkg::ST_SUM:    state_d = fvf_pkg::ST_UPD;
      fvf_pkg::ST_UPD:    state_d = fvf_pkg::ST_OUT;
      fvf_pkg::ST_OUT:    if (out_ld) state_d = fvf_pkg::ST_IDLE;
      default:            state_d = fvf_pkg::ST_IDLE;
    endcase
  end

  // ---- control outputs
  always_comb begin
    q_pop_o          = (state_q == fvf_pkg::ST_IDLE) && q_valid_i;
    out_ld           = (state_q == fvf_pkg::ST_OUT) && (!out_valid_q || out_ready_i);
    ram_we           = (state_q == fvf_pkg::ST_FILL);
    ram_waddr        = fill_cnt_q;
    ram_wdata        = e_val[16] ? 16'hFFFF : e_val[15:0];
    ram_raddr        = idx[AW-1:0];
    div_req.start    = 1'b0;
    div_req.dividend = {item_q.dt_us, 21'd0};
    div_req.divisor  = divisor_q;
    unique case (state_q)
      fvf_pkg::ST_RD0: ram_raddr = over ? LAST_ADDR : idx_m1[AW-1:0];
      fvf_pkg::ST_U_GO: div_req.start = 1'b1;
      default: ;
    endcase
  end

  // ---- control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= fvf_pkg::ST_FILL;
      fill_cnt_q  <= '0;
      acc_q       <= fvf_pkg::EXP_STEP_Q32;
      vel_x_q     <= '0;
      vel_y_q     <= '0;
      last_x_q    <= '0;
      last_y_q    <= '0;
      seeded_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == fvf_pkg::ST_FILL) begin
        fill_cnt_q <= fill_cnt_q + AW'(1);
        acc_q      <= acc_rnd[63:32];
      end
      if (state_q == fvf_pkg::ST_UPD) begin
        vel_x_q  <= sat_x;
        vel_y_q  <= sat_y;
        last_x_q <= item_q.accel_x;
        last_y_q <= item_q.accel_y;
        seeded_q <= 1'b1;
      end
      if (out_ld) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // ---- datapath registers
  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      item_q <= q_item_i;
    end
    if (out_ld) begin
      out_x_q <= vel_x_q;
      out_y_q <= vel_y_q;
    end
    unique case (state_q)
      fvf_pkg::ST_PREP: begin
        divisor_q <= 26'(settle_eff) * 26'(fvf_pkg::MS_SCALE);
        cprod_x_q <= dfx * alt_s;
        cprod_y_q <= dfy * alt_s;
        num_x_q   <= lsum_x * dt_s;
        num_y_q   <= lsum_y * dt_s;
      end
      fvf_pkg::ST_U_GO: begin
        cam_x_q <= cam_sum_x[33:3];
        cam_y_q <= cam_sum_y[33:3];
      end
      fvf_pkg::ST_U_WAIT: if (div_rsp.done) u_q <= div_rsp.quot;
      fvf_pkg::ST_RD1: p0_q <= (idx == 21'd0) ? fvf_pkg::ONE_Q16 : {1'b0, ram_rdata};
      fvf_pkg::ST_RD2: p1_q <= {1'b0, ram_rdata};
      fvf_pkg::ST_INTERP: iprod_q <= 33'(p0_q - p1_q) * 33'(u_q[15:0]);
      fvf_pkg::ST_ALPHA: alpha_q <= over ? p0_q : p0_q - irnd[32:16];
      fvf_pkg::ST_X_GO: begin
        rcp_lo_q <= 52'(dvd_x) * 52'(fvf_pkg::INC_RECIP_LO);
        rcp_hi_q <= 53'(dvd_x) * 53'(fvf_pkg::INC_RECIP_HI);
      end
      fvf_pkg::ST_X_WAIT: begin
        inc_x_q <= num_x_q[33] ? -$signed(inc_mag) : $signed(inc_mag);
      end
      fvf_pkg::ST_Y_GO: begin
        rcp_lo_q <= 52'(dvd_y) * 52'(fvf_pkg::INC_RECIP_LO);
        rcp_hi_q <= 53'(dvd_y) * 53'(fvf_pkg::INC_RECIP_HI);
      end
      fvf_pkg::ST_Y_WAIT: begin
        inc_y_q <= num_y_q[33] ? -$signed(inc_mag) : $signed(inc_mag);
      end
      fvf_pkg::ST_MUL: begin
        mv_x_q <= a_s * vel_x_q;
        mc_x_q <= b_s * cam_x_q;
        mv_y_q <= a_s * vel_y_q;
        mc_y_q <= b_s * cam_y_q;
      end
      fvf_pkg::ST_SUM: begin
        mix_x_q <= mv_x_q + mc_x_q + 50'sd32768;
        mix_y_q <= mv_y_q + mc_y_q + 50'sd32768;
      end
      default: ;
    endcase
  end

  assign out_valid_o = out_valid_q;
  assign vel_x_o     = out_x_q;
  assign vel_y_o     = out_y_q;

endmodule

### rtl/core/flow_imu_velocity_fuser_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// flow_imu_velocity_fuser_core
// Two-axis complementary velocity fuser of optical flow and imu acceleration.
// ----------------------------------------------------------------------------
// usage
//   input channel (in_valid_i / in_ready_o) takes one sensor sample per
//   transaction: flow, gyro, accel, altitude and dt_us
//   output channel (out_valid_o / out_ready_i) returns one velocity pair,
//   q16.16, for every sample, in order
//   apb port: settling_time_ms at 0x0, min_altitude at 0x4; the user writes
//   only while the block is idle, which the block itself does not enforce
// processing
//   a sample with dt_us of zero goes from ST_IDLE straight to ST_OUT and
//   returns the held velocity through the output register
//   other samples run the one-bit-per-cycle divider for the leak step,
//   then the x and y trapezoid increments, each a registered reciprocal
//   multiply; the back end pops the next sample only after ST_OUT
// reset
//   after reset the alpha table is built into the ram, one entry per cycle,
//   until all ALPHA_TABLE_DEPTH entries are written; samples queue meanwhile and wait
// stall
//   a two-entry queue and the output register let the input side keep
//   taking samples while a result waits on a stalled receiver
// ----------------------------------------------------------------------------
module flow_imu_velocity_fuser_core #(
  parameter int unsigned ALPHA_TABLE_DEPTH = fvf_pkg::ALPHA_TABLE_DEPTH
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  // sample channel
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic signed [15:0] flow_x_i,
  input  logic signed [15:0] flow_y_i,
  input  logic signed [15:0] gyro_x_i,
  input  logic signed [15:0] gyro_y_i,
  input  logic signed [15:0] accel_x_i,
  input  logic signed [15:0] accel_y_i,
  input  logic [15:0]        altitude_i,
  input  logic [15:0]        dt_us_i,
  // velocity channel
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [31:0] vel_x_o,
  output logic signed [31:0] vel_y_o,
  // apb config port
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  fvf_pkg::item_t   in_item, q_item;
  logic             q_valid, q_pop;
  logic [15:0]      settle_q, min_alt_q;
  logic             cfg_wr;
  fvf_pkg::reg_idx_e cfg_idx;

  // register index comes from address bit 2, low bits ignored
  assign cfg_idx = fvf_pkg::reg_idx_e'(paddr[2]);
  assign cfg_wr  = psel && penable && pwrite;
  assign pready  = 1'b1;

  always_comb begin
    unique case (cfg_idx)
      fvf_pkg::REG_SETTLE:  prdata = {16'd0, settle_q};
      fvf_pkg::REG_MIN_ALT: prdata = {16'd0, min_alt_q};
      default:              prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      settle_q  <= fvf_pkg::SETTLE_RESET;
      min_alt_q <= fvf_pkg::MIN_ALT_RESET;
    end else if (cfg_wr) begin
      if (cfg_idx == fvf_pkg::REG_SETTLE) begin
        settle_q <= pwdata[15:0];
      end else begin
        min_alt_q <= pwdata[15:0];
      end
    end
  end

  // pack sample fields; skip flag is set by the front end
  always_comb begin
    in_item.flow_x   = flow_x_i;
    in_item.flow_y   = flow_y_i;
    in_item.gyro_x   = gyro_x_i;
    in_item.gyro_y   = gyro_y_i;
    in_item.accel_x  = accel_x_i;
    in_item.accel_y  = accel_y_i;
    in_item.altitude = altitude_i;
    in_item.dt_us    = dt_us_i;
    in_item.skip     = 1'b0;
  end

  fvf_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .in_ready_o(in_ready_o),
    .in_item_i (in_item),
    .q_valid_o (q_valid),
    .q_item_o  (q_item),
    .q_pop_i   (q_pop)
  );

  fvf_back #(
    .ALPHA_TABLE_DEPTH(ALPHA_TABLE_DEPTH)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .q_valid_i  (q_valid),
    .q_item_i   (q_item),
    .q_pop_o    (q_pop),
    .settle_i   (settle_q),
    .min_alt_i  (min_alt_q),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .vel_x_o    (vel_x_o),
    .vel_y_o    (vel_y_o)
  );

  // back end only pops a queued sample
  assert property (@(posedge clk_i) disable iff (!rst_ni) q_pop |-> q_valid)
    else $error("pop from empty queue");

  // an empty queue always has room
  assert property (@(posedge clk_i) disable iff (!rst_ni) !q_valid |-> in_ready_o)
    else $error("input stalled with empty queue");

  // a pop drains one entry, so the queue has room on the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop && !(in_valid_i && in_ready_o) |=> in_ready_o)
    else $error("queue still full after pop");

endmodule

### sim/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench of the flow / imu velocity fuser core.
// ----------------------------------------------------------------------------
// a directed table runs first, then random samples are sent in phases, each
// under its own register setting; a behavioral velocity predictor computes
// the expected pair of every accepted sample, and each returned transaction
// is compared with the oldest expected pair
// ----------------------------------------------------------------------------
module testbench;

  localparam int unsigned TABLE_DEPTH = fvf_pkg::ALPHA_TABLE_DEPTH;
  localparam int unsigned CYCLE_LIMIT = 2000000;
  localparam int unsigned PHASE_ITEMS = 300;

  typedef struct {
    logic signed [15:0] flow_x, flow_y, gyro_x, gyro_y, accel_x, accel_y;
    logic [15:0]        altitude, dt_us;
    bit                 known;
    logic signed [31:0] vel_x, vel_y;
  } sample_t;

  typedef struct {
    logic signed [31:0] vel_x, vel_y;
  } vel_pair_t;

  logic clk_i, rst_ni;
  logic in_valid_i, in_ready_o, out_valid_o, out_ready_i;
  logic signed [15:0] flow_x_i, flow_y_i, gyro_x_i, gyro_y_i, accel_x_i, accel_y_i;
  logic [15:0] altitude_i, dt_us_i;
  logic signed [31:0] vel_x_o, vel_y_o;
  logic psel, penable, pwrite, pready;
  logic [2:0] paddr;
  logic [31:0] pwdata, prdata;

  // predictor state
  logic [15:0]        settle_ms, min_alt;
  logic signed [31:0] vel_x_st, vel_y_st;
  logic signed [15:0] last_ax, last_ay;
  bit                 seeded;
  logic [15:0]        alpha_tab [TABLE_DEPTH];

  vel_pair_t vel_expected_q[$];
  int unsigned mismatches;
  int unsigned cycles = 0;
  bit quiet;  // no idling on either side

  flow_imu_velocity_fuser_core i_dut (
    .clk_i, .rst_ni,
    .in_valid_i, .in_ready_o,
    .flow_x_i, .flow_y_i, .gyro_x_i, .gyro_y_i, .accel_x_i, .accel_y_i,
    .altitude_i, .dt_us_i,
    .out_valid_o, .out_ready_i, .vel_x_o, .vel_y_o,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // watchdog
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // exp(-(i+1)/8) table built by repeated rounded multiplication
  function automatic void build_alpha_tab();
    bit [63:0] acc;
    bit [63:0] e;
    acc = 64'd1 << 32;
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      acc = (acc * 64'(fvf_pkg::EXP_STEP_Q32) + (64'd1 << 31)) >> 32;
      e   = (acc + 64'd32768) >> 16;
      alpha_tab[i] = (e > 64'd65535) ? 16'hFFFF : e[15:0];
    end
  endfunction

  function automatic longint tab_point(longint k);
    if (k == 0) return 65536;
    return longint'(alpha_tab[k - 1]);
  endfunction

  // leak factor in unsigned q1.16 from the interpolated table
  function automatic longint leak_factor(logic [15:0] dt);
    longint settle, u, idx, frac, p0, p1;
    settle = (settle_ms == 0) ? 1 : longint'(settle_ms);
    u      = (longint'(dt) << 21) / (settle * 1000);
    idx    = u >> 16;
    frac   = u & 16'hFFFF;
    if (idx >= TABLE_DEPTH) return longint'(alpha_tab[TABLE_DEPTH - 1]);
    p0 = tab_point(idx);
    p1 = tab_point(idx + 1);
    return p0 - (((p0 - p1) * frac + 32768) >>> 16);
  endfunction

  function automatic logic signed [31:0] fuse_axis(longint v, longint flow, longint gyro,
                                                   longint acc, longint last, longint alt,
                                                   longint dt, longint alpha);
    longint cam, num, mag, inc, mix, sum;
    cam = ((flow - gyro) * alt + 4) >>> 3;
    num = (acc + last) * dt * 2;
    mag = (num < 0) ? -num : num;
    inc = (mag + 7812) / 15625;
    if (num < 0) inc = -inc;
    mix = alpha * v + (65536 - alpha) * cam;
    sum = inc + ((mix + 32768) >>> 16);
    if (sum > 64'sd2147483647) return 32'sh7FFFFFFF;
    if (sum < -64'sd2147483648) return 32'sh80000000;
    return sum[31:0];
  endfunction

  // advances the predictor by one sample, returns the velocity pair
  function automatic vel_pair_t fuse_predict(sample_t s);
    vel_pair_t r;
    longint alpha, alt;
    if (s.dt_us != 0) begin
      alpha = leak_factor(s.dt_us);
      alt   = (s.altitude < min_alt) ? longint'(min_alt) : longint'(s.altitude);
      if (!seeded) begin
        last_ax = s.accel_x;
        last_ay = s.accel_y;
        seeded  = 1'b1;
      end
      vel_x_st = fuse_axis(vel_x_st, s.flow_x, s.gyro_x, s.accel_x, last_ax, alt,
                           s.dt_us, alpha);
      vel_y_st = fuse_axis(vel_y_st, s.flow_y, s.gyro_y, s.accel_y, last_ay, alt,
                           s.dt_us, alpha);
      last_ax = s.accel_x;
      last_ay = s.accel_y;
    end
    r.vel_x = vel_x_st;
    r.vel_y = vel_y_st;
    return r;
  endfunction

  // apb write: setup then access cycle
  task automatic reg_write(fvf_pkg::reg_idx_e idx, logic [15:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= 3'(idx) << 2;
    pwdata  <= {16'h0, value};
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (idx == fvf_pkg::REG_SETTLE) settle_ms = value;
    else min_alt = value;
  endtask

  // lets every expected transaction come back, then a latency margin
  task automatic drain();
    while (vel_expected_q.size() != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
  endtask

  // holds valid until accepted, then maybe idles for a burst
  task automatic send_sample(sample_t s);
    vel_pair_t p;
    in_valid_i <= 1'b1;
    flow_x_i   <= s.flow_x;
    flow_y_i   <= s.flow_y;
    gyro_x_i   <= s.gyro_x;
    gyro_y_i   <= s.gyro_y;
    accel_x_i  <= s.accel_x;
    accel_y_i  <= s.accel_y;
    altitude_i <= s.altitude;
    dt_us_i    <= s.dt_us;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    p = fuse_predict(s);
    if (s.known) begin
      p.vel_x = s.vel_x;
      p.vel_y = s.vel_y;
    end
    vel_expected_q.push_back(p);
    if (!quiet && $urandom_range(3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(7, 1)) @(posedge clk_i);
    end
  endtask

  // field value biased toward the extremes
  function automatic logic [15:0] pick16();
    case ($urandom_range(7))
      0: return 16'h8000;
      1: return 16'h7FFF;
      2: return 16'h0000;
      3: return 16'hFFFF;
      4: return 16'($urandom_range(255));
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic sample_t random_sample();
    sample_t s;
    s.flow_x   = pick16();
    s.flow_y   = pick16();
    s.gyro_x   = pick16();
    s.gyro_y   = pick16();
    s.accel_x  = pick16();
    s.accel_y  = pick16();
    s.altitude = pick16();
    case ($urandom_range(9))
      0: s.dt_us = 16'd0;
      1: s.dt_us = 16'($urandom);
      2: s.dt_us = 16'hFFFF;
      default: s.dt_us = 16'($urandom_range(5000, 1));
    endcase
    s.known = 1'b0;
    return s;
  endfunction

  // receiver side: random stall bursts, checks each transaction
  initial begin
    int unsigned stall;
    vel_pair_t exp_v;
    out_ready_i = 1'b0;
    stall = 0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_valid_o && out_ready_i) begin
        if (vel_expected_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected transaction: vel_x %0d vel_y %0d", vel_x_o, vel_y_o);
        end else begin
          exp_v = vel_expected_q.pop_front();
          if (vel_x_o !== exp_v.vel_x || vel_y_o !== exp_v.vel_y) begin
            mismatches++;
            if (mismatches <= 10)
              $display("velocity mismatch: expected %0d %0d, actual %0d %0d",
                       exp_v.vel_x, exp_v.vel_y, vel_x_o, vel_y_o);
          end
        end
      end
      if (stall == 0 && !quiet && $urandom_range(4) == 0) stall = $urandom_range(7, 1);
      if (stall != 0) begin
        stall--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  // directed table; vel pair typed in only where it is obvious
  sample_t directed [$] = '{
    // dt of zero right after reset returns the reset velocity
    '{16'sh7FFF, 16'sh8000, 16'sh0000, 16'sh0000, 16'sh1234, 16'sh4321, 16'h0100,
      16'd0, 1'b1, 32'sd0, 32'sd0},
    // first sample seeds the previous acceleration, extreme accel
    '{16'sh0000, 16'sh0000, 16'sh0000, 16'sh0000, 16'sh7FFF, 16'sh8000, 16'h0100,
      16'd1000, 1'b0, 32'sd0, 32'sd0},
    '{16'sh7FFF, 16'sh8000, 16'sh8000, 16'sh7FFF, 16'sh7FFF, 16'sh8000, 16'hFFFF,
      16'd1000, 1'b0, 32'sd0, 32'sd0},
    '{16'sh8000, 16'sh7FFF, 16'sh7FFF, 16'sh8000, 16'sh8000, 16'sh7FFF, 16'hFFFF,
      16'hFFFF, 1'b0, 32'sd0, 32'sd0},
    // altitude under the floor is clamped
    '{16'sh0800, 16'shF800, 16'sh0000, 16'sh0000, 16'sh0000, 16'sh0000, 16'h0000,
      16'd500, 1'b0, 32'sd0, 32'sd0},
    '{16'sh0800, 16'sh0800, 16'sh0100, 16'shFF00, 16'sh0100, 16'shFF00, 16'h0019,
      16'd1, 1'b0, 32'sd0, 32'sd0},
    // zero step holds the velocity
    '{16'sh1111, 16'sh2222, 16'sh3333, 16'sh4444, 16'sh5555, 16'sh6666, 16'h7777,
      16'd0, 1'b0, 32'sd0, 32'sd0},
    '{16'sh7FFF, 16'sh7FFF, 16'sh8000, 16'sh8000, 16'sh7FFF, 16'sh7FFF, 16'hFFFF,
      16'd65535, 1'b0, 32'sd0, 32'sd0},
    '{16'sh0000, 16'sh0000, 16'sh0000, 16'sh0000, 16'sh0000, 16'sh0000, 16'h0000,
      16'd2000, 1'b0, 32'sd0, 32'sd0},
    '{16'shFFFF, 16'sh0001, 16'sh0001, 16'shFFFF, 16'shFFFF, 16'sh0001, 16'h0001,
      16'd250, 1'b0, 32'sd0, 32'sd0}
  };

  initial begin
    int unsigned phase;
    in_valid_i = 1'b0;
    flow_x_i = '0; flow_y_i = '0; gyro_x_i = '0; gyro_y_i = '0;
    accel_x_i = '0; accel_y_i = '0; altitude_i = '0; dt_us_i = '0;
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
    mismatches = 0;
    quiet = 1'b0;
    settle_ms = fvf_pkg::SETTLE_RESET;
    min_alt   = fvf_pkg::MIN_ALT_RESET;
    vel_x_st = 0; vel_y_st = 0; last_ax = 0; last_ay = 0; seeded = 1'b0;
    build_alpha_tab();
    rst_ni = 1'b0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (directed[i]) send_sample(directed[i]);
    in_valid_i <= 1'b0;
    drain();

    // steps far past the table end with the shortest settling time
    reg_write(fvf_pkg::REG_SETTLE, 16'd1);
    reg_write(fvf_pkg::REG_MIN_ALT, 16'd0);
    for (int i = 0; i < 8; i++) begin
      sample_t s;
      s = random_sample();
      s.dt_us = (i < 4) ? 16'hFFFF : 16'd2000 + 16'(i);
      send_sample(s);
    end

    for (phase = 0; phase < 6; phase++) begin
      in_valid_i <= 1'b0;
      drain();
      case (phase)
        0: begin
          reg_write(fvf_pkg::REG_SETTLE, 16'd1000);
          reg_write(fvf_pkg::REG_MIN_ALT, 16'd26);
        end
        1: begin
          reg_write(fvf_pkg::REG_SETTLE, 16'hFFFF);
          reg_write(fvf_pkg::REG_MIN_ALT, 16'hFFFF);
        end
        2: begin
          reg_write(fvf_pkg::REG_SETTLE, 16'd0);
          reg_write(fvf_pkg::REG_MIN_ALT, 16'd0);
        end
        3: begin
          reg_write(fvf_pkg::REG_SETTLE, 16'd1);
          reg_write(fvf_pkg::REG_MIN_ALT, 16'h8000);
        end
        default: begin
          reg_write(fvf_pkg::REG_SETTLE, 16'($urandom_range(2000, 1)));
          reg_write(fvf_pkg::REG_MIN_ALT, 16'($urandom));
        end
      endcase
      quiet = (phase == 5);
      repeat (PHASE_ITEMS) send_sample(random_sample());
    end
    in_valid_i <= 1'b0;
    drain();

    if (mismatches == 0 && vel_expected_q.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
